/* src/lsra_pkg.sv */
// ----------------------------------------------------------------------------
// lsra_pkg: shared types and constants of the linear scan register allocator
// Field widths, the active-list entry, cell control and the FSM encoding.
// ----------------------------------------------------------------------------
package lsra_pkg;

   localparam int MAX_REGS     = 8;
   localparam int POS_BITS     = 16;
   localparam int ID_BITS      = 16;

   localparam int REG_IDX_BITS = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1;
   localparam int SPILL_BITS   = ID_BITS + 1;
   localparam int RNUM_BITS    = 6;
   localparam int OFFSET_BITS  = 20;

   localparam int COUNT_BITS   = 4;
   localparam int FIRST_BITS   = 5;
   localparam int SLOT_BITS    = 4;
   localparam int CSR_IDX_BITS = 2;
   localparam int CSR_DATA_BITS = 5;

   localparam logic [CSR_IDX_BITS-1:0] CSR_REGISTER_COUNT = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FIRST_REGISTER = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SLOT_BYTES     = 2'd2;

   localparam logic [COUNT_BITS-1:0] COUNT_RESET = 4'd8;
   localparam logic [FIRST_BITS-1:0] FIRST_RESET = 5'd2;
   localparam logic [SLOT_BITS-1:0]  SLOT_RESET  = 4'd4;

   localparam logic [MAX_REGS-1:0] ALL_FREE = {MAX_REGS{1'b1}};

   typedef struct packed {
      logic [ID_BITS-1:0]  interval_id;
      logic [POS_BITS-1:0] start_pos;
      logic [POS_BITS-1:0] end_pos;
      logic                new_batch;
   } req_word_type;

   typedef struct packed {
      logic [ID_BITS-1:0]     result_id;
      logic                   in_register;
      logic [RNUM_BITS-1:0]   register_number;
      logic [OFFSET_BITS-1:0] spill_offset;
      logic [SPILL_BITS-1:0]  spills_so_far;
      logic                   last_of_run;
   } rsp_word_type;

   typedef struct packed {
      logic                    valid;
      logic [POS_BITS-1:0]     end_pos;
      logic [REG_IDX_BITS-1:0] reg_idx;
      logic [ID_BITS-1:0]      id;
   } entry_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_EXPIRE,
      CELL_INSERT,
      CELL_SHIFT
   } cell_op_type;

   typedef struct packed {
      cell_op_type         op;
      logic                clear;
      logic [POS_BITS-1:0] start_pos;
      entry_type           new_entry;
   } cell_ctl_type;

   typedef struct packed {
      entry_type entry;
      logic      yield_slot;
      logic      freed;
   } cell_stat_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_REMOVE,
      ST_INSERT
   } fsm_state_type;

endpackage

/* src/lsra_cell.sv */
// ----------------------------------------------------------------------------
// lsra_cell: one slot of the active interval list
// The list is packed from cell 0 upward in descending end order. A cell can
// expire, take its neighbor's entry on insert, or shift down on removal.
// ----------------------------------------------------------------------------
module lsra_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  lsra_pkg::cell_ctl_type  ctl,
   input  lsra_pkg::entry_type     prev_entry,
   input  logic                 prev_yield,
   input  lsra_pkg::entry_type     next_entry,
   output lsra_pkg::cell_stat_type stat
);
   import lsra_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;
   logic      yield_slot;
   logic      expired;

   always_comb begin
      // entries with an end not past the new one move one cell up
      yield_slot = !(entry_ff.valid && (entry_ff.end_pos > ctl.new_entry.end_pos));
      expired    = ctl.clear || (entry_ff.end_pos < ctl.start_pos);
      entry_in   = entry_ff;
      unique case (ctl.op)
         CELL_HOLD: begin
            entry_in = entry_ff;
         end
         CELL_EXPIRE: begin
            if (expired) begin
               entry_in.valid = 1'b0;
            end
         end
         CELL_INSERT: begin
            if (yield_slot) begin
               entry_in = prev_yield ? prev_entry : ctl.new_entry;
            end
         end
         CELL_SHIFT: begin
            entry_in = next_entry;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   always_comb begin
      stat.entry      = entry_ff;
      stat.yield_slot = yield_slot;
      stat.freed      = entry_ff.valid && !ctl.clear && (entry_ff.end_pos < ctl.start_pos);
   end

endmodule

/* src/linear_scan_register_allocator.sv */
// ----------------------------------------------------------------------------
// linear_scan_register_allocator: linear scan allocation over sorted intervals
// Sequencing: the first result word is registered from the decide state after
// the input word is taken; an eviction emits its second word from the insert
// state, after the remove step. A new interval is taken only in idle, so each
// runs expire / decide (/ shift / insert) of the cell chain before the next.
// Reset: synchronous; empties the active list, frees all registers, clears
// the spill count and loads the register defaults (8 registers, first 2,
// 4-byte slots).
// ----------------------------------------------------------------------------
module linear_scan_register_allocator (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  lsra_pkg::req_word_type                req_word,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output lsra_pkg::rsp_word_type                rsp_word,
   input  logic                                  csr_we,
   input  logic [lsra_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [lsra_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);
   import lsra_pkg::*;

   fsm_state_type state_ff, state_in;

   logic [COUNT_BITS-1:0] csr_count_ff;
   logic [FIRST_BITS-1:0] csr_first_ff;
   logic [SLOT_BITS-1:0]  csr_slot_ff;

   logic [MAX_REGS-1:0]     free_ff, free_in;
   logic [SPILL_BITS-1:0]   spill_ff, spill_in;
   logic [ID_BITS-1:0]      item_id_ff, item_id_in;
   logic [POS_BITS-1:0]     item_end_ff, item_end_in;
   logic [REG_IDX_BITS-1:0] victim_reg_ff, victim_reg_in;

   logic         rsp_valid_ff;
   rsp_word_type rsp_word_ff;
   logic         emit;
   rsp_word_type emit_word;

   cell_ctl_type  cell_ctl;
   cell_stat_type cell_stat [MAX_REGS];
   entry_type     prev_entry [MAX_REGS];
   entry_type     next_entry [MAX_REGS];
   logic          prev_yield [MAX_REGS];

   logic                    accept;
   logic                    out_free;
   logic [MAX_REGS-1:0]     freed_mask;
   logic [MAX_REGS-1:0]     cand_mask;
   logic [REG_IDX_BITS-1:0] alloc_idx;
   logic                    got;
   logic                    victim;
   logic [SPILL_BITS-1:0]   spill_next;
   logic [OFFSET_BITS-1:0]  slot_offset;

   // ---------------------------------------------------------------- cells
   always_comb begin
      prev_entry[0] = '0;
      prev_yield[0] = 1'b0;
      for (int i = 1; i < MAX_REGS; i++) begin
         prev_entry[i] = cell_stat[i-1].entry;
         prev_yield[i] = cell_stat[i-1].yield_slot;
      end
      next_entry[MAX_REGS-1] = '0;
      for (int i = 0; i < MAX_REGS - 1; i++) begin
         next_entry[i] = cell_stat[i+1].entry;
      end
   end

   for (genvar g = 0; g < MAX_REGS; g++) begin : g_cell
      lsra_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (cell_ctl),
         .prev_entry (prev_entry[g]),
         .prev_yield (prev_yield[g]),
         .next_entry (next_entry[g]),
         .stat       (cell_stat[g])
      );
   end

   // ------------------------------------------------------ decision logic
   always_comb begin
      freed_mask = '0;
      for (int i = 0; i < MAX_REGS; i++) begin
         for (int k = 0; k < MAX_REGS; k++) begin
            if (cell_stat[i].freed && (cell_stat[i].entry.reg_idx == REG_IDX_BITS'(k))) begin
               freed_mask[k] = 1'b1;
            end
         end
      end
      for (int k = 0; k < MAX_REGS; k++) begin
         cand_mask[k] = free_ff[k] && (k < int'(csr_count_ff));
      end
      alloc_idx = '0;
      for (int k = MAX_REGS - 1; k >= 0; k--) begin
         if (cand_mask[k]) begin
            alloc_idx = REG_IDX_BITS'(k);
         end
      end
      got    = !cell_stat[MAX_REGS-1].entry.valid && (|cand_mask);
      victim = cell_stat[0].entry.valid && (cell_stat[0].entry.end_pos > item_end_ff);
      // counter saturates at 2^ID_BITS
      spill_next  = spill_ff[SPILL_BITS-1] ? spill_ff : spill_ff + SPILL_BITS'(1);
      slot_offset = OFFSET_BITS'(spill_ff) * OFFSET_BITS'(csr_slot_ff);
   end

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // --------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (out_free) begin
               priority if (got) begin
                  state_in = ST_IDLE;
               end else if (victim) begin
                  state_in = ST_REMOVE;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_REMOVE: begin
            state_in = ST_INSERT;
         end
         ST_INSERT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------ outputs
   always_comb begin
      req_stall              = (state_ff != ST_IDLE);
      cell_ctl.op            = CELL_HOLD;
      cell_ctl.clear         = req_word.new_batch;
      cell_ctl.start_pos     = req_word.start_pos;
      cell_ctl.new_entry.valid   = 1'b1;
      cell_ctl.new_entry.end_pos = item_end_ff;
      cell_ctl.new_entry.reg_idx = alloc_idx;
      cell_ctl.new_entry.id      = item_id_ff;
      free_in       = free_ff;
      spill_in      = spill_ff;
      item_id_in    = item_id_ff;
      item_end_in   = item_end_ff;
      victim_reg_in = victim_reg_ff;
      emit          = 1'b0;
      emit_word     = '0;
      emit_word.spills_so_far = spill_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cell_ctl.op = CELL_EXPIRE;
               free_in     = (req_word.new_batch ? ALL_FREE : free_ff) | freed_mask;
               spill_in    = req_word.new_batch ? '0 : spill_ff;
               item_id_in  = req_word.interval_id;
               item_end_in = (req_word.end_pos < req_word.start_pos) ?
                             req_word.start_pos : req_word.end_pos;
            end
         end
         ST_DECIDE: begin
            if (out_free) begin
               emit = 1'b1;
               priority if (got) begin
                  cell_ctl.op = CELL_INSERT;
                  free_in     = free_ff & ~(MAX_REGS'(1) << alloc_idx);
                  emit_word.result_id       = item_id_ff;
                  emit_word.in_register     = 1'b1;
                  emit_word.register_number = RNUM_BITS'(csr_first_ff) + RNUM_BITS'(alloc_idx);
                  emit_word.last_of_run     = 1'b1;
               end else if (victim) begin
                  // evict the active interval with the latest end
                  victim_reg_in = cell_stat[0].entry.reg_idx;
                  spill_in      = spill_next;
                  emit_word.result_id     = cell_stat[0].entry.id;
                  emit_word.spill_offset  = slot_offset;
                  emit_word.spills_so_far = spill_next;
               end else begin
                  spill_in      = spill_next;
                  emit_word.result_id     = item_id_ff;
                  emit_word.spill_offset  = slot_offset;
                  emit_word.spills_so_far = spill_next;
                  emit_word.last_of_run   = 1'b1;
               end
            end
         end
         ST_REMOVE: begin
            cell_ctl.op = CELL_SHIFT;
         end
         ST_INSERT: begin
            cell_ctl.new_entry.reg_idx = victim_reg_ff;
            if (out_free) begin
               cell_ctl.op = CELL_INSERT;
               emit        = 1'b1;
               emit_word.result_id       = item_id_ff;
               emit_word.in_register     = 1'b1;
               emit_word.register_number = RNUM_BITS'(csr_first_ff) + RNUM_BITS'(victim_reg_ff);
               emit_word.last_of_run     = 1'b1;
            end
         end
         default: begin
            cell_ctl.op = CELL_HOLD;
         end
      endcase
   end

   // ----------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         free_ff      <= ALL_FREE;
         spill_ff     <= '0;
         csr_count_ff <= COUNT_RESET;
         csr_first_ff <= FIRST_RESET;
         csr_slot_ff  <= SLOT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         free_ff  <= free_in;
         spill_ff <= spill_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_REGISTER_COUNT: csr_count_ff <= csr_wdata[COUNT_BITS-1:0];
               CSR_FIRST_REGISTER: csr_first_ff <= csr_wdata[FIRST_BITS-1:0];
               CSR_SLOT_BYTES:     csr_slot_ff  <= csr_wdata[SLOT_BITS-1:0];
               default: begin
                  csr_count_ff <= csr_count_ff;
               end
            endcase
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      item_id_ff    <= item_id_in;
      item_end_ff   <= item_end_in;
      victim_reg_ff <= victim_reg_in;
      if (emit) begin
         rsp_word_ff <= emit_word;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

/* sim/linear_scan_register_allocator_tb.sv */
// ----------------------------------------------------------------------------
// linear_scan_register_allocator_tb: self-checking bench for the allocator
// A scoreboard class tracks live intervals, the free pool and the spill count,
// and predicts each result word from the accepted interval words. Directed
// cases cover clamping, expiry, eviction, zero registers, zero slots, an
// oversize count and mid-batch setting changes. Random sorted runs follow,
// with noise and random idling on both sides.
// ----------------------------------------------------------------------------
module linear_scan_register_allocator_tb;
   import lsra_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 1000000;
   localparam int unsigned HOLD_OFF    = 8;
   localparam int unsigned SPILL_CAP   = 1 << ID_BITS;

   class alloc_scoreboard;
      logic [COUNT_BITS-1:0] reg_count;
      logic [FIRST_BITS-1:0] base_reg;
      logic [SLOT_BITS-1:0]  slot_size;
      int unsigned           live_end   [MAX_REGS];
      int unsigned           live_idx   [MAX_REGS];
      logic [ID_BITS-1:0]    live_id    [MAX_REGS];
      int unsigned           live_count;
      logic [MAX_REGS-1:0]   free_pool;
      int unsigned           slots_used;
      rsp_word_type          expected_allocs [$];
      int unsigned           errors;

      function new();
         reg_count = COUNT_RESET;
         base_reg  = FIRST_RESET;
         slot_size = SLOT_RESET;
         errors    = 0;
         clear_batch();
      endfunction

      function void clear_batch();
         live_count = 0;
         free_pool  = ALL_FREE;
         slots_used = 0;
      endfunction

      function int unsigned pending();
         return expected_allocs.size();
      endfunction

      function void write_register(logic [CSR_IDX_BITS-1:0] idx,
                                   logic [CSR_DATA_BITS-1:0] val);
         case (idx)
            CSR_REGISTER_COUNT: reg_count = val[COUNT_BITS-1:0];
            CSR_FIRST_REGISTER: base_reg  = val[FIRST_BITS-1:0];
            CSR_SLOT_BYTES:     slot_size = val[SLOT_BITS-1:0];
            default: ;
         endcase
      endfunction

      function void post(logic [ID_BITS-1:0] id, bit in_reg, int unsigned idx,
                         int unsigned off, bit last);
         rsp_word_type r;
         int unsigned  rnum;
         rnum              = base_reg + idx;
         r.result_id       = id;
         r.in_register     = in_reg;
         r.register_number = in_reg ? rnum[RNUM_BITS-1:0] : '0;
         r.spill_offset    = in_reg ? '0 : off[OFFSET_BITS-1:0];
         r.spills_so_far   = slots_used[SPILL_BITS-1:0];
         r.last_of_run     = last;
         expected_allocs.push_back(r);
      endfunction

      function int unsigned take_slot();
         int unsigned off;
         off = slots_used * slot_size;
         if (slots_used < SPILL_CAP) slots_used++;
         return off;
      endfunction

      // live list stays sorted by end; equal ends go behind older entries
      function void insert_live(logic [ID_BITS-1:0] id, int unsigned fin,
                                int unsigned idx);
         int unsigned at;
         int unsigned r;
         if (live_count >= MAX_REGS) return;
         at = live_count;
         for (r = 0; r < live_count; r++) begin
            if (live_end[r] > fin) begin
               at = r;
               break;
            end
         end
         for (r = live_count; r > at; r--) begin
            live_end[r] = live_end[r-1];
            live_idx[r] = live_idx[r-1];
            live_id[r]  = live_id[r-1];
         end
         live_end[at] = fin;
         live_idx[at] = idx;
         live_id[at]  = id;
         live_count++;
      endfunction

      function void note_interval(req_word_type w);
         int unsigned        start;
         int unsigned        fin;
         int unsigned        cnt;
         int unsigned        keep;
         int unsigned        r;
         int unsigned        k;
         int unsigned        idx;
         int unsigned        off;
         bit                 got;
         logic [ID_BITS-1:0] old_id;
         if (w.new_batch) clear_batch();
         start = w.start_pos;
         fin   = w.end_pos;
         if (fin < start) fin = start;
         cnt  = (reg_count > MAX_REGS) ? MAX_REGS : reg_count;
         keep = 0;
         for (r = 0; r < live_count; r++) begin
            if (live_end[r] < start) begin
               free_pool[live_idx[r] % MAX_REGS] = 1'b1;
            end else begin
               live_end[keep] = live_end[r];
               live_idx[keep] = live_idx[r];
               live_id[keep]  = live_id[r];
               keep++;
            end
         end
         live_count = keep;
         got = 1'b0;
         idx = 0;
         if (live_count < MAX_REGS) begin
            for (k = 0; k < cnt && !got; k++) begin
               if (free_pool[k]) begin
                  got          = 1'b1;
                  idx          = k;
                  free_pool[k] = 1'b0;
               end
            end
         end
         if (got) begin
            insert_live(w.interval_id, fin, idx);
            post(w.interval_id, 1'b1, idx, 0, 1'b1);
         end else if (live_count > 0 && live_end[live_count-1] > fin) begin
            // evict the longest-lived entry, the new interval takes its register
            old_id = live_id[live_count-1];
            idx    = live_idx[live_count-1];
            live_count--;
            off = take_slot();
            post(old_id, 1'b0, 0, off, 1'b0);
            insert_live(w.interval_id, fin, idx);
            post(w.interval_id, 1'b1, idx, 0, 1'b1);
         end else begin
            off = take_slot();
            post(w.interval_id, 1'b0, 0, off, 1'b1);
         end
      endfunction

      function void flag(string what, rsp_word_type exp, rsp_word_type got);
         errors++;
         if (errors <= 10) begin
            $display("[%0t] alloc %s: exp id=%0d inreg=%0b reg=%0d off=%0d spills=%0d last=%0b",
                     $time, what, exp.result_id, exp.in_register, exp.register_number,
                     exp.spill_offset, exp.spills_so_far, exp.last_of_run);
            $display("   got id=%0d inreg=%0b reg=%0d off=%0d spills=%0d last=%0b",
                     got.result_id, got.in_register, got.register_number,
                     got.spill_offset, got.spills_so_far, got.last_of_run);
         end
      endfunction

      function void check_result(rsp_word_type got);
         rsp_word_type exp;
         if (expected_allocs.size() == 0) begin
            flag("word with none expected", '0, got);
            return;
         end
         exp = expected_allocs.pop_front();
         if (got.result_id !== exp.result_id ||
             got.in_register !== exp.in_register ||
             got.register_number !== exp.register_number ||
             got.spill_offset !== exp.spill_offset ||
             got.spills_so_far !== exp.spills_so_far ||
             got.last_of_run !== exp.last_of_run)
            flag("mismatch", exp, got);
      endfunction
   endclass

   logic                     clock;
   logic                     reset     = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   req_word_type             req_word  = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   rsp_word_type             rsp_word;
   logic                     csr_we    = 1'b0;
   logic [CSR_IDX_BITS-1:0]  csr_index = CSR_REGISTER_COUNT;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   alloc_scoreboard board;
   int unsigned     send_idle = 14;
   int unsigned     recv_idle = 84;
   int unsigned     cycle_count = 0;
   int unsigned     cursor = 0;

   linear_scan_register_allocator u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** linear_scan_register_allocator: FAILED **");
         $finish;
      end
   end

   // result side: check accepted words, then pick the stall for the next edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_result(rsp_word);
      rsp_stall <= ($urandom_range(99) < recv_idle);
   end

   function automatic req_word_type make_interval(int unsigned id, int unsigned start,
                                                  int unsigned fin, bit fresh);
      req_word_type w;
      w.interval_id = id[ID_BITS-1:0];
      w.start_pos   = start[POS_BITS-1:0];
      w.end_pos     = fin[POS_BITS-1:0];
      w.new_batch   = fresh;
      return w;
   endfunction

   task automatic send_interval(input req_word_type w);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_interval(w);
   endtask

   // drain every expected word, then give the pipeline time to go idle
   task automatic settle();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (HOLD_OFF) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_BITS-1:0] idx, input int unsigned val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[CSR_DATA_BITS-1:0];
      @(posedge clock);
      board.write_register(idx, val[CSR_DATA_BITS-1:0]);
   endtask

   task automatic apply_settings(input int unsigned count, input int unsigned first,
                                 input int unsigned slot);
      write_csr(CSR_REGISTER_COUNT, count);
      write_csr(CSR_FIRST_REGISTER, first);
      write_csr(CSR_SLOT_BYTES, slot);
      csr_we <= 1'b0;
   endtask

   task automatic send_random_run(input int unsigned n_items, input bit fresh);
      req_word_type w;
      int unsigned  i;
      int unsigned  pick;
      int unsigned  span;
      int unsigned  fin;
      for (i = 0; i < n_items; i++) begin
         pick = (fresh && i == 0) ? 0 : $urandom_range(99);
         w.interval_id = $urandom_range(65535);
         w.new_batch   = 1'b0;
         if (pick < 4) begin
            w.new_batch = 1'b1;
            cursor = ($urandom_range(3) == 0) ? $urandom_range(65535, 65000)
                                              : $urandom_range(65535);
         end
         if (pick >= 4 && pick < 9) begin
            // noise: arbitrary positions, out of order
            w.start_pos = $urandom_range(65535);
            w.end_pos   = $urandom_range(65535);
            w.new_batch = $urandom_range(1);
         end else begin
            cursor = cursor + $urandom_range(3);
            if (cursor > 65535) cursor = 65535;
            span = ($urandom_range(15) == 0) ? $urandom_range(20000) : $urandom_range(40);
            fin  = cursor + span;
            if (fin > 65535) fin = 65535;
            if ($urandom_range(19) == 0) fin = $urandom_range(cursor);
            w.start_pos = cursor;
            w.end_pos   = fin;
         end
         if (pick == 99) settle();
         send_interval(w);
      end
   endtask

   initial begin
      int unsigned p;
      board = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset settings: clamp, fill all eight, expiry, eviction, spill of new
      send_interval(make_interval(0, 0, 0, 1'b1));
      send_interval(make_interval(65535, 0, 65535, 1'b0));
      send_interval(make_interval(1, 1, 0, 1'b0));
      send_interval(make_interval(2, 2, 50, 1'b0));
      send_interval(make_interval(3, 3, 60, 1'b0));
      send_interval(make_interval(4, 4, 70, 1'b0));
      send_interval(make_interval(5, 5, 80, 1'b0));
      send_interval(make_interval(6, 6, 90, 1'b0));
      send_interval(make_interval(7, 7, 100, 1'b0));
      send_interval(make_interval(8, 8, 30, 1'b0));
      send_interval(make_interval(9, 9, 40, 1'b0));
      send_interval(make_interval(10, 10, 65535, 1'b0));
      send_interval(make_interval(11, 200, 200, 1'b0));
      send_interval(make_interval(12, 100, 150, 1'b0));
      send_interval(make_interval(13, 65535, 65535, 1'b1));

      // no registers and zero-byte slots: everything spills at offset 0
      settle();
      apply_settings(0, 31, 0);
      send_interval(make_interval(20, 0, 10, 1'b1));
      send_interval(make_interval(21, 1, 5, 1'b0));
      send_interval(make_interval(22, 2, 2, 1'b0));

      // oversize count acts as eight
      settle();
      apply_settings(15, 0, 8);
      send_interval(make_interval(30, 0, 1000, 1'b1));
      send_interval(make_interval(31, 1, 1000, 1'b0));
      send_interval(make_interval(32, 2, 20, 1'b0));
      send_interval(make_interval(33, 3, 1000, 1'b0));

      // count lowered and first register moved mid batch
      settle();
      apply_settings(2, 17, 1);
      send_interval(make_interval(34, 30, 1000, 1'b0));
      send_interval(make_interval(35, 31, 500, 1'b0));
      send_interval(make_interval(36, 1200, 1300, 1'b0));

      for (p = 0; p < 12; p++) begin
         if (p == 4) begin
            send_idle = 84;
            recv_idle = 14;
         end
         if (p == 8) begin
            send_idle = 0;
            recv_idle = 0;
         end
         settle();
         case (p)
            1: apply_settings(15, 31, 15);
            2: apply_settings(1, 0, 1);
            6: apply_settings(0, 16, 8);
            9: apply_settings(8, 31, 0);
            default: apply_settings(($urandom_range(3) == 0) ? $urandom_range(15)
                                                             : $urandom_range(8),
                                    $urandom_range(31), $urandom_range(15));
         endcase
         send_random_run(125, $urandom_range(1));
      end

      settle();
      if (board.errors == 0 && board.pending() == 0)
         $display("** linear_scan_register_allocator: PASSED **");
      else
         $display("** linear_scan_register_allocator: FAILED **");
      $finish;
   end

endmodule
